[design/md5_pkg.sv]
`timescale 1ns / 1ps
package md5_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LEN,
      ST_ROUND,
      ST_FOLD,
      ST_EMIT
   } md5_state_type;

   // Datapath commands for the current cycle.
   typedef struct packed {
      logic       write_byte;  // write wr_byte at the fill index and advance it
      logic [7:0] wr_byte;
      logic       count_byte;  // add eight to the bit count
      logic       snap_len;    // latch the bit count as the message length
      logic       start_block; // load the working words from the chain words
      logic       do_round;    // run one round
      logic       fold;        // add the working words into the chain words
      logic       clear_ctx;   // return the context to its initial values
   } md5_cmd_type;

   typedef struct packed {
      logic [5:0]  fill;
      logic [5:0]  round;
      logic [63:0] len;
   } md5_stat_type;

   localparam logic [7:0] PadByte = 8'h80;
   localparam logic [5:0] LenStart = 6'd56;

   localparam logic [31:0] InitA = 32'h67452301;
   localparam logic [31:0] InitB = 32'hefcdab89;
   localparam logic [31:0] InitC = 32'h98badcfe;
   localparam logic [31:0] InitD = 32'h10325476;

   function automatic logic [31:0] sine_k(input logic [5:0] i);
      logic [31:0] t [64];
      t = '{
         32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
         32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
         32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
         32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
         32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
         32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
         32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
         32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
         32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
         32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
         32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
         32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
         32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
         32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
         32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
         32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
      return t[i];
   endfunction

   function automatic logic [4:0] rot_s(input logic [5:0] i);
      logic [4:0] t [16];
      t = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
            5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};
      return t[{i[5:4], i[1:0]}];
   endfunction

   // Message word used in round i.
   function automatic logic [3:0] msg_index(input logic [5:0] i);
      logic [3:0] r;
      unique case (i[5:4])
         2'd0: r = i[3:0];
         2'd1: r = 4'(5 * i[3:0] + 1);
         2'd2: r = 4'(3 * i[3:0] + 5);
         default: r = 4'(7 * i[3:0]);
      endcase
      return r;
   endfunction

endpackage

[design/md5_ram.sv]
`timescale 1ns / 1ps
module md5_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[design/md5_datapath.sv]
`timescale 1ns / 1ps
module md5_datapath (
   input  logic                clock,
   input  logic                reset,
   input  md5_pkg::md5_cmd_type cmd,
   input  logic [1:0]          emit_sel,
   output md5_pkg::md5_stat_type stat,
   output logic [31:0]         chain_word
);
   import md5_pkg::*;

   logic [5:0]  fill_ff, fill_in;
   logic [5:0]  round_ff, round_in;
   logic [63:0] count_ff, count_in;
   logic [63:0] len_ff;
   logic [31:0] ha_ff, hb_ff, hc_ff, hd_ff;
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [31:0] m_word;
   logic [31:0] f_val, t_val, rot_val;
   logic [63:0] rot_wide;
   logic [5:0]  prefetch;

   // The buffer is kept as 16 little-endian words, four byte lanes.
   logic [3:0][7:0] lane_rd;
   logic [3:0]      lane_we;

   // The word for round r+1 is read during round r; start_block reads round 0.
   assign prefetch = cmd.start_block ? 6'd0 : 6'(round_ff + 6'd1);

   for (genvar g = 0; g < 4; g++) begin : gen_lane
      assign lane_we[g] = cmd.write_byte && (fill_ff[1:0] == 2'(g));
      md5_ram #(.Width(8), .Depth(16)) u_lane (
         .clock  (clock),
         .wr_en  (lane_we[g]),
         .wr_addr(fill_ff[5:2]),
         .wr_data(cmd.wr_byte),
         .rd_addr(msg_index(prefetch)),
         .rd_data(lane_rd[g])
      );
   end
   assign m_word = lane_rd;

   always_comb begin
      unique case (round_ff[5:4])
         2'd0: f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1: f_val = (d_ff & b_ff) | (~d_ff & c_ff);
         2'd2: f_val = b_ff ^ c_ff ^ d_ff;
         default: f_val = c_ff ^ (b_ff | ~d_ff);
      endcase
      t_val = a_ff + f_val + sine_k(round_ff) + m_word;
      rot_wide = {t_val, t_val} << rot_s(round_ff);
      rot_val = rot_wide[63:32];
   end

   always_comb begin
      fill_in = fill_ff;
      count_in = count_ff;
      round_in = round_ff;
      if (cmd.write_byte) begin
         fill_in = 6'(fill_ff + 6'd1);
      end
      if (cmd.count_byte) begin
         count_in = count_ff + 64'd8;
      end
      if (cmd.start_block) begin
         round_in = '0;
      end else if (cmd.do_round) begin
         round_in = 6'(round_ff + 6'd1);
      end
      if (cmd.clear_ctx) begin
         fill_in = '0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         count_ff <= '0;
         round_ff <= '0;
         ha_ff <= InitA;
         hb_ff <= InitB;
         hc_ff <= InitC;
         hd_ff <= InitD;
      end else begin
         fill_ff <= fill_in;
         count_ff <= count_in;
         round_ff <= round_in;
         if (cmd.clear_ctx) begin
            ha_ff <= InitA;
            hb_ff <= InitB;
            hc_ff <= InitC;
            hd_ff <= InitD;
         end else if (cmd.fold) begin
            ha_ff <= ha_ff + a_ff;
            hb_ff <= hb_ff + b_ff;
            hc_ff <= hc_ff + c_ff;
            hd_ff <= hd_ff + d_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.snap_len) begin
         len_ff <= count_ff;
      end
      if (cmd.start_block) begin
         a_ff <= ha_ff;
         b_ff <= hb_ff;
         c_ff <= hc_ff;
         d_ff <= hd_ff;
      end else if (cmd.do_round) begin
         a_ff <= d_ff;
         d_ff <= c_ff;
         c_ff <= b_ff;
         b_ff <= b_ff + rot_val;
      end
   end

   always_comb begin
      unique case (emit_sel)
         2'd0: chain_word = ha_ff;
         2'd1: chain_word = hb_ff;
         2'd2: chain_word = hc_ff;
         default: chain_word = hd_ff;
      endcase
   end

   assign stat.fill = fill_ff;
   assign stat.round = round_ff;
   assign stat.len = len_ff;
endmodule

[design/md5_control.sv]
`timescale 1ns / 1ps
module md5_control (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,
   input  logic                  req_tuser,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [1:0]            emit_sel,
   input  md5_pkg::md5_stat_type stat,
   output md5_pkg::md5_cmd_type  cmd
);
   import md5_pkg::*;

   md5_state_type state_ff, state_in;
   md5_state_type after_ff, after_in;   // where to continue once a block is folded
   logic          wrap_ff, wrap_in;     // length does not fit; zero-fill to block end first
   logic [1:0]    idx_ff, idx_in;
   logic [2:0]    lenb_ff, lenb_in;
   logic [63:0]   len_shift;

   assign len_shift = stat.len >> {lenb_ff, 3'b000};
   assign emit_sel = idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         after_ff <= ST_IDLE;
         wrap_ff <= 1'b0;
         idx_ff <= '0;
         lenb_ff <= '0;
      end else begin
         state_ff <= state_in;
         after_ff <= after_in;
         wrap_ff <= wrap_in;
         idx_ff <= idx_in;
         lenb_ff <= lenb_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      after_in = after_ff;
      wrap_in = wrap_ff;
      idx_in = idx_ff;
      lenb_in = lenb_ff;
      cmd = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.write_byte = req_tuser;
               cmd.wr_byte = req_tdata;
               cmd.count_byte = req_tuser;
               if (req_tuser && stat.fill == 6'd63) begin
                  // Buffer full: compress; padding follows if this is the end.
                  cmd.start_block = 1'b1;
                  after_in = req_tlast ? ST_PAD : ST_IDLE;
                  state_in = ST_ROUND;
               end else if (req_tlast) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            // Length is taken here, after the last message byte was counted.
            cmd.write_byte = 1'b1;
            cmd.wr_byte = PadByte;
            cmd.snap_len = 1'b1;
            wrap_in = 1'b0;
            state_in = ST_LEN;
            if (stat.fill == 6'd63) begin
               cmd.start_block = 1'b1;
               after_in = ST_LEN;
               state_in = ST_ROUND;
            end else if (stat.fill >= LenStart) begin
               wrap_in = 1'b1;
            end
         end
         ST_LEN: begin
            cmd.write_byte = 1'b1;
            if (wrap_ff || stat.fill < LenStart) begin
               cmd.wr_byte = '0;
            end else begin
               cmd.wr_byte = len_shift[7:0];
               lenb_in = 3'(lenb_ff + 3'd1);
            end
            if (stat.fill == 6'd63) begin
               cmd.start_block = 1'b1;
               state_in = ST_ROUND;
               if (wrap_ff) begin
                  // The length goes into one more block of zeros.
                  wrap_in = 1'b0;
                  after_in = ST_LEN;
               end else begin
                  lenb_in = '0;
                  after_in = ST_EMIT;
               end
            end
         end
         ST_ROUND: begin
            cmd.do_round = 1'b1;
            if (stat.round == 6'd63) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            state_in = after_ff;
         end
         ST_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               idx_in = 2'(idx_ff + 2'd1);
               if (idx_ff == 2'd3) begin
                  cmd.clear_ctx = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

[design/md5_hash_engine.sv]
`timescale 1ns / 1ps
// Byte-serial MD5 engine. A request item carries one message byte (tuser set) or none,
// and tlast ends the message; the digest then leaves as four 32-bit words A to D, each
// little-endian, with tlast on D. Bytes are taken while the engine is idle; each 64th
// byte starts a compression, one round per cycle on a single round unit, and then a
// fold, with no request taken meanwhile. Padding writes one byte a cycle into the
// block buffer, pausing for one or two compressions, before the digest.
module md5_hash_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tuser,   // has_byte
   input  logic        req_tlast,   // is_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // digest_word[31:0], word_index[33:32], zero fill
   output logic        rsp_tlast    // last_word
);
   import md5_pkg::*;

   md5_cmd_type  cmd;
   md5_stat_type stat;
   logic [1:0]   emit_sel;
   logic [31:0]  chain_word;

   md5_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .emit_sel  (emit_sel),
      .stat      (stat),
      .cmd       (cmd)
   );

   md5_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .emit_sel  (emit_sel),
      .stat      (stat),
      .chain_word(chain_word)
   );

   assign rsp_tdata = {6'd0, emit_sel, chain_word};
   assign rsp_tlast = (emit_sel == 2'd3);
endmodule

[test/md5_hash_engine_tb.sv]
`timescale 1ns / 1ps
module md5_hash_engine_tb;

   typedef struct packed {
      logic       has_byte;
      logic [7:0] data_byte;
      logic       is_last;
   } msg_item_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [1:0]  word_index;
      logic        last_word;
   } digest_item_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;

   md5_hash_engine u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   localparam logic [31:0] SineTab [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
   localparam int ShiftTab [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                    4, 11, 16, 23, 6, 10, 15, 21};

   // Digest context of the predictor.
   logic [31:0] chain [4];
   logic [7:0]  blk [64];
   logic [63:0] msg_bits;
   logic [5:0]  fill;

   msg_item_type    pending_msgs[$];
   digest_item_type expected_digests[$];
   int              mismatches;
   bit              timed_out;
   bit              hold_rsp;
   bit              req_tready_seen;
   int              accepted_msgs;

   function automatic void clear_context();
      chain[0] = 32'h67452301;
      chain[1] = 32'hefcdab89;
      chain[2] = 32'h98badcfe;
      chain[3] = 32'h10325476;
      msg_bits = '0;
      fill = '0;
   endfunction

   function automatic void compress();
      logic [31:0] m [16];
      logic [31:0] a, b, c, d, f, t;
      int g;
      int s;
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
      for (int i = 0; i < 16; i++)
         m[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
      for (int i = 0; i < 64; i++) begin
         case (i / 16)
            0: begin f = (b & c) | (~b & d); g = i; end
            1: begin f = (d & b) | (~d & c); g = (5 * i + 1) % 16; end
            2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
            default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
         endcase
         t = a + f + SineTab[i] + m[g];
         a = d; d = c; c = b;
         s = ShiftTab[(i / 16) * 4 + i % 4];
         t = (t << s) | (t >> (32 - s));
         b = b + t;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
   endfunction

   function automatic void append_byte(logic [7:0] v);
      blk[fill] = v;
      fill = fill + 6'd1;
      if (fill == 0) compress();
   endfunction

   function automatic void predict_digest(msg_item_type it);
      logic [63:0] len;
      if (it.has_byte) begin
         append_byte(it.data_byte);
         msg_bits += 64'd8;
      end
      if (!it.is_last) return;
      len = msg_bits;
      append_byte(8'h80);
      while (fill != 6'd56) append_byte(8'h00);
      for (int k = 0; k < 8; k++) append_byte(len[8*k +: 8]);
      for (int k = 0; k < 4; k++)
         expected_digests.push_back('{chain[k], 2'(k), k == 3});
      clear_context();
   endfunction

   function automatic void add_message(int nbytes, bit end_empty, bit noisy);
      msg_item_type it;
      for (int i = 0; i < nbytes; i++) begin
         if (noisy && $urandom_range(0, 7) == 0)
            pending_msgs.push_back('{1'b0, 8'($urandom), 1'b0});
         it = '{1'b1, 8'($urandom), 1'b0};
         if (i == nbytes - 1 && !end_empty) it.is_last = 1'b1;
         pending_msgs.push_back(it);
      end
      if (end_empty || nbytes == 0)
         pending_msgs.push_back('{1'b0, 8'($urandom), 1'b1});
   endfunction

   function automatic int gap_len();
      if ($urandom_range(0, 3) != 0) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      timed_out = 1'b1;
      $display("Simulation FAILED");
      $finish;
   end

   // Driver: takes items from the pending queue, with random gaps.
   int           drv_gap;
   msg_item_type cur_msg;
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         drv_gap = 0;
      end else if (!req_tvalid || req_tready_seen) begin
         if (drv_gap > 0) begin
            drv_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_msgs.size() > 0) begin
            cur_msg = pending_msgs.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= cur_msg.has_byte;
            req_tdata <= cur_msg.data_byte;
            req_tlast <= cur_msg.is_last;
            drv_gap = gap_len();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Acceptance is sampled at the rising edge and consumed at the next falling edge.
   always @(posedge clock) begin
      req_tready_seen <= req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         predict_digest(msg_item_type'{req_tuser, req_tdata, req_tlast});
         accepted_msgs++;
      end
   end

   // Monitor: checks each digest word against the oldest expectation.
   digest_item_type seen, want;
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = '{rsp_tdata[31:0], rsp_tdata[33:32], rsp_tlast};
         if (expected_digests.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected digest word %h", seen);
         end else begin
            want = expected_digests.pop_front();
            if (seen !== want || rsp_tdata[39:34] !== 6'd0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"Digest mismatch: expected word %h idx %0d last %0b,",
                            " got %h idx %0d last %0b"},
                           want.digest_word, want.word_index, want.last_word,
                           seen.digest_word, seen.word_index, seen.last_word);
            end
         end
      end
   end

   // Receiver stalls, plus one long hold-off while the sender keeps going.
   int rsp_gap;
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_gap = 0;
      end else if (hold_rsp) begin
         rsp_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         rsp_gap = gap_len();
      end
   end

   initial begin
      int hold_cycles;
      hold_rsp = 1'b0;
      hold_cycles = 0;
      @(posedge clock);
      wait (accepted_msgs > 40);
      hold_rsp = 1'b1;
      while (hold_cycles < 600) begin
         @(posedge clock);
         hold_cycles++;
      end
      hold_rsp = 1'b0;
   end

   initial begin
      int settle;
      mismatches = 0;
      timed_out = 1'b0;
      accepted_msgs = 0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      clear_context();
      reset = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty message, idle item, extreme bytes, padding boundaries.
      pending_msgs.push_back('{1'b0, 8'hff, 1'b0});
      pending_msgs.push_back('{1'b0, 8'h00, 1'b1});
      pending_msgs.push_back('{1'b1, 8'h00, 1'b1});
      pending_msgs.push_back('{1'b1, 8'hff, 1'b0});
      pending_msgs.push_back('{1'b0, 8'h55, 1'b0});
      pending_msgs.push_back('{1'b0, 8'haa, 1'b1});
      add_message(55, 1'b0, 1'b0);
      add_message(56, 1'b1, 1'b0);
      add_message(63, 1'b0, 1'b0);

      // Sender pauses until the engine has drained every digest.
      wait (pending_msgs.size() == 0 && accepted_msgs > 0);
      @(posedge clock);
      while (expected_digests.size() > 0 || req_tvalid) @(posedge clock);
      @(negedge clock);

      add_message(64, 1'b0, 1'b1);
      for (int n = 0; n < 2; n++)
         add_message($urandom_range(0, 20), $urandom_range(0, 1), 1'b1);

      wait (pending_msgs.size() == 0);
      @(posedge clock);
      while (req_tvalid) @(posedge clock);
      while (expected_digests.size() > 0) @(posedge clock);
      settle = 0;
      while (settle < 200) begin
         @(posedge clock);
         settle++;
      end
      if (mismatches == 0 && expected_digests.size() == 0 && !timed_out)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
